>>> design/brs_pkg.sv
// Shared types, constants and controller encodings for the block range add / range sum unit.
// Used by brs_ram, brs_ctrl, brs_dpath and block_range_add_range_sum_unit; depends on nothing.

package brs_pkg;

   // Default build sizes.
   localparam int unsigned MAX_ELEMENTS_DEF = 1024;
   localparam int unsigned BLOCK_LEN_DEF    = 32;

   // Fixed field widths.
   localparam int unsigned IDX_W = 10;
   localparam int unsigned CFG_W = 11;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned SUM_W = 64;

   // Reset value of the elements-in-use register.
   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;
   localparam logic [1:0] FUNC_IGNORE = 2'd3;

   // One request item.
   typedef struct packed {
      logic [1:0]              func;
      logic [IDX_W-1:0]        left_index;
      logic [IDX_W-1:0]        right_index;
      logic signed [VAL_W-1:0] value;
   } brs_req_type;

   // One result item.
   typedef struct packed {
      logic signed [SUM_W-1:0] range_sum;
      logic                    range_error;
   } brs_rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_BASE,
      ST_OPEN,
      ST_WALK,
      ST_WALK_END,
      ST_CLOSE,
      ST_MID,
      ST_MID_END,
      ST_WRITE_RD,
      ST_WRITE_WR,
      ST_DONE
   } brs_state_type;

   // Commands from the controller to the datapath; at most one is high in a cycle.
   typedef struct packed {
      logic clear;
      logic capture;
      logic quot;
      logic base;
      logic open;
      logic walk;
      logic close;
      logic mid;
      logic wr_read;
      logic wr_write;
      logic result;
   } brs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       clear_last;
      logic [1:0] func;
      logic       range_bad;
      logic       at_last;
      logic       next_last;
      logic       pos_at_end;
      logic       rsp_free;
   } brs_status_type;

endpackage

>>> design/brs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on brs_pkg for its default sizes.

module brs_ram #(
   parameter int unsigned WIDTH = brs_pkg::VAL_W,
   parameter int unsigned DEPTH = brs_pkg::MAX_ELEMENTS_DEF,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/brs_ctrl.sv
// Controller state machine for the block range add / range sum unit.
// Depends on brs_pkg for the state, command and status types.

module brs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  brs_pkg::brs_status_type status,
   output brs_pkg::brs_cmd_type    cmd
);

   brs_pkg::brs_state_type state_ff;
   brs_pkg::brs_state_type state_in;

   // State register; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         brs_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = brs_pkg::ST_IDLE;
            end
         end
         brs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = brs_pkg::ST_QUOT;
            end
         end
         brs_pkg::ST_QUOT: begin
            cmd.quot = 1'b1;
            if (status.func == brs_pkg::FUNC_IGNORE) begin
               state_in = brs_pkg::ST_IDLE;
            end else if (status.range_bad) begin
               state_in = brs_pkg::ST_DONE;
            end else if (status.func == brs_pkg::FUNC_WRITE) begin
               state_in = brs_pkg::ST_WRITE_RD;
            end else begin
               state_in = brs_pkg::ST_BASE;
            end
         end
         brs_pkg::ST_BASE: begin
            cmd.base = 1'b1;
            state_in = brs_pkg::ST_OPEN;
         end
         brs_pkg::ST_OPEN: begin
            cmd.open = 1'b1;
            state_in = brs_pkg::ST_WALK;
         end
         brs_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.pos_at_end) begin
               state_in = brs_pkg::ST_WALK_END;
            end
         end
         brs_pkg::ST_WALK_END: begin
            state_in = brs_pkg::ST_CLOSE;
         end
         brs_pkg::ST_CLOSE: begin
            cmd.close = 1'b1;
            if (status.at_last) begin
               state_in = brs_pkg::ST_DONE;
            end else if (status.next_last) begin
               state_in = brs_pkg::ST_OPEN;
            end else begin
               state_in = brs_pkg::ST_MID;
            end
         end
         brs_pkg::ST_MID: begin
            cmd.mid = 1'b1;
            if (status.next_last) begin
               state_in = brs_pkg::ST_MID_END;
            end
         end
         brs_pkg::ST_MID_END: begin
            state_in = brs_pkg::ST_OPEN;
         end
         brs_pkg::ST_WRITE_RD: begin
            cmd.wr_read = 1'b1;
            state_in    = brs_pkg::ST_WRITE_WR;
         end
         brs_pkg::ST_WRITE_WR: begin
            cmd.wr_write = 1'b1;
            state_in     = brs_pkg::ST_DONE;
         end
         brs_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.result = 1'b1;
               state_in   = brs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brs_pkg::ST_IDLE;
         end
      endcase
   end

   // An accepted request always goes on to the block lookup.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == brs_pkg::ST_QUOT)
      else $error("accepted request did not move to block lookup");

   // The datapath never sees two commands in one cycle.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

endmodule

>>> design/brs_dpath.sv
// Datapath for the block range add / range sum unit: item and result registers,
// block lookup, walk counters and the element, tag and block-sum RAMs.
// Depends on brs_pkg and brs_ram.

module brs_dpath #(
   parameter int unsigned MAX_ELEMENTS = brs_pkg::MAX_ELEMENTS_DEF,
   parameter int unsigned BLOCK_LEN    = brs_pkg::BLOCK_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brs_pkg::brs_cmd_type          cmd,
   output brs_pkg::brs_status_type       status,
   input  brs_pkg::brs_req_type          req_payload,
   input  logic                          csr_valid,
   input  logic [brs_pkg::CFG_W-1:0]     csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output brs_pkg::brs_rsp_type          rsp_payload
);

   localparam int unsigned IDX_W       = brs_pkg::IDX_W;
   localparam int unsigned CFG_W       = brs_pkg::CFG_W;
   localparam int unsigned VAL_W       = brs_pkg::VAL_W;
   localparam int unsigned SUM_W       = brs_pkg::SUM_W;
   localparam int unsigned BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
   localparam int unsigned ELEM_AW     = $clog2(MAX_ELEMENTS);
   localparam int unsigned BLK_AW      = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int unsigned LOG_D       = $clog2(BLOCK_LEN);
   localparam int unsigned CNT_W       = LOG_D + 1;
   localparam int unsigned SHIFT       = IDX_W + LOG_D;
   localparam int unsigned RCP_W       = IDX_W + 2;
   localparam int unsigned PROD_W      = IDX_W + RCP_W;
   localparam int unsigned RECIP       = ((1 << SHIFT) + BLOCK_LEN - 1) / BLOCK_LEN;
   localparam int unsigned MUL_W       = CNT_W + VAL_W + 1;

   // Registers.
   brs_pkg::brs_req_type   item_ff, item_in;
   brs_pkg::brs_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]       eiu_ff, eiu_in;
   logic [IDX_W-1:0]       sb_ff, sb_in, tb_ff, tb_in;
   logic [IDX_W-1:0]       blk_ff, blk_in, base_ff, base_in;
   logic [IDX_W-1:0]       pos_ff, pos_in, end_ff, end_in;
   logic [IDX_W-1:0]       walk_pos_ff, walk_pos_in, mid_blk_ff, mid_blk_in;
   logic                   walk_vld_ff, walk_vld_in, mid_vld_ff, mid_vld_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_W-1:0]       part_prod_ff, part_prod_in, mid_prod_ff, mid_prod_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [ELEM_AW-1:0]     clr_ff, clr_in;

   // Combinational helpers.
   logic [CFG_W-1:0]       lim;
   logic [PROD_W-1:0]      l_prod, r_prod;
   logic                   is_add, is_query, at_first, at_last, range_bad, clear_blk;
   logic [IDX_W-1:0]       seg_start, seg_end;
   logic [IDX_W:0]         seg_cnt;
   logic [VAL_W-1:0]       x_bits, elem_sum;
   logic [SUM_W-1:0]       elem_val64, wr_diff64;
   logic signed [VAL_W:0]  wr_diff;
   logic signed [MUL_W-1:0] part_mul, mid_mul;

   // RAM ports.
   logic                   elem_we, elem_re, tag_we, tag_re, sum_we, sum_re;
   logic [ELEM_AW-1:0]     elem_waddr, elem_raddr;
   logic [BLK_AW-1:0]      tag_waddr, sum_waddr, blk_raddr;
   logic [VAL_W-1:0]       elem_wdata, elem_rdata, tag_wdata, tag_rdata;
   logic [SUM_W-1:0]       sum_wdata, sum_rdata;

   // Range limit and range checks on the held item.
   always_comb begin
      lim       = (32'(eiu_ff) < MAX_ELEMENTS) ? eiu_ff : CFG_W'(MAX_ELEMENTS);
      is_add    = item_ff.func == brs_pkg::FUNC_ADD;
      is_query  = item_ff.func == brs_pkg::FUNC_QUERY;
      if (item_ff.func == brs_pkg::FUNC_WRITE) begin
         range_bad = {1'b0, item_ff.left_index} >= lim;
      end else begin
         range_bad = (item_ff.left_index > item_ff.right_index) ||
                     ({1'b0, item_ff.right_index} >= lim);
      end
   end

   // Block number of both ends by multiplying with a scaled reciprocal of the block length.
   assign l_prod = PROD_W'(item_ff.left_index) * PROD_W'(RECIP);
   assign r_prod = PROD_W'(item_ff.right_index) * PROD_W'(RECIP);

   // Segment bounds of the block at hand.
   always_comb begin
      at_first  = blk_ff == sb_ff;
      at_last   = blk_ff == tb_ff;
      seg_start = at_first ? item_ff.left_index : base_ff;
      seg_end   = at_last ? item_ff.right_index : base_ff + IDX_W'(BLOCK_LEN - 1);
      seg_cnt   = {1'b0, seg_end} - {1'b0, seg_start} + (IDX_W+1)'(1);
   end

   // Element arithmetic.
   always_comb begin
      x_bits     = item_ff.value;
      elem_sum   = elem_rdata + tag_rdata;
      elem_val64 = {{(SUM_W-VAL_W){elem_sum[VAL_W-1]}}, elem_sum};
      wr_diff    = $signed({x_bits[VAL_W-1], x_bits}) - $signed({elem_sum[VAL_W-1], elem_sum});
      wr_diff64  = {{(SUM_W-VAL_W-1){wr_diff[VAL_W]}}, wr_diff};
      part_mul   = $signed({1'b0, cnt_ff}) * $signed(x_bits);
      mid_mul    = $signed({1'b0, CNT_W'(BLOCK_LEN)}) * $signed(x_bits);
      clear_blk  = 32'(clr_ff) < BLOCK_COUNT;
   end

   // Next values of the datapath registers.
   always_comb begin
      item_in      = cmd.capture ? req_payload : item_ff;
      eiu_in       = csr_valid ? csr_data : eiu_ff;
      sb_in        = cmd.quot ? IDX_W'(l_prod >> SHIFT) : sb_ff;
      tb_in        = cmd.quot ? IDX_W'(r_prod >> SHIFT) : tb_ff;
      blk_in       = blk_ff;
      base_in      = base_ff;
      if (cmd.base) begin
         blk_in  = sb_ff;
         base_in = sb_ff * IDX_W'(BLOCK_LEN);
      end else if (cmd.mid || (cmd.close && !at_last)) begin
         blk_in  = blk_ff + IDX_W'(1);
         base_in = base_ff + IDX_W'(BLOCK_LEN);
      end
      pos_in       = cmd.open ? seg_start : (cmd.walk ? pos_ff + IDX_W'(1) : pos_ff);
      end_in       = cmd.open ? seg_end : end_ff;
      cnt_in       = cmd.open ? CNT_W'(seg_cnt) : cnt_ff;
      walk_vld_in  = cmd.walk;
      walk_pos_in  = pos_ff;
      mid_vld_in   = cmd.mid;
      mid_blk_in   = blk_ff;
      part_prod_in = {{(SUM_W-MUL_W){part_mul[MUL_W-1]}}, part_mul};
      mid_prod_in  = {{(SUM_W-MUL_W){mid_mul[MUL_W-1]}}, mid_mul};
      clr_in       = cmd.clear ? clr_ff + ELEM_AW'(1) : clr_ff;
      // Query sum: element values in end blocks, block sums in between.
      acc_in       = acc_ff;
      if (cmd.capture) begin
         acc_in = '0;
      end else if (walk_vld_ff && is_query) begin
         acc_in = acc_ff + elem_val64;
      end else if (mid_vld_ff && is_query) begin
         acc_in = acc_ff + sum_rdata;
      end
      // Result register: the finished item waits here while the next is taken.
      rsp_valid_in = cmd.result ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (cmd.result) begin
         rsp_data_in.range_sum   = acc_ff;
         rsp_data_in.range_error = range_bad;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff       <= brs_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
         walk_vld_ff  <= 1'b0;
         mid_vld_ff   <= 1'b0;
         clr_ff       <= '0;
      end else begin
         eiu_ff       <= eiu_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_vld_ff  <= walk_vld_in;
         mid_vld_ff   <= mid_vld_in;
         clr_ff       <= clr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_data_ff  <= rsp_data_in;
      sb_ff        <= sb_in;
      tb_ff        <= tb_in;
      blk_ff       <= blk_in;
      base_ff      <= base_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      cnt_ff       <= cnt_in;
      walk_pos_ff  <= walk_pos_in;
      mid_blk_ff   <= mid_blk_in;
      part_prod_ff <= part_prod_in;
      mid_prod_ff  <= mid_prod_in;
      acc_ff       <= acc_in;
   end

   // Element RAM access.
   always_comb begin
      elem_re    = cmd.walk || cmd.wr_read;
      elem_raddr = cmd.wr_read ? ELEM_AW'(item_ff.left_index) : ELEM_AW'(pos_ff);
      elem_we    = cmd.clear || cmd.wr_write || (walk_vld_ff && is_add);
      elem_waddr = ELEM_AW'(walk_pos_ff);
      elem_wdata = elem_rdata + x_bits;
      if (cmd.clear) begin
         elem_waddr = clr_ff;
         elem_wdata = '0;
      end else if (cmd.wr_write) begin
         elem_waddr = ELEM_AW'(item_ff.left_index);
         elem_wdata = x_bits - tag_rdata;
      end
   end

   // Tag and block-sum RAM access.
   always_comb begin
      blk_raddr = cmd.wr_read ? BLK_AW'(sb_ff) : BLK_AW'(blk_ff);
      tag_re    = cmd.open || cmd.mid || cmd.wr_read;
      sum_re    = tag_re;
      tag_we    = (cmd.clear && clear_blk) || (mid_vld_ff && is_add);
      tag_waddr = cmd.clear ? BLK_AW'(clr_ff) : BLK_AW'(mid_blk_ff);
      tag_wdata = cmd.clear ? '0 : tag_rdata + x_bits;
      sum_we    = (cmd.clear && clear_blk) || cmd.wr_write ||
                  (cmd.close && is_add) || (mid_vld_ff && is_add);
      sum_waddr = BLK_AW'(mid_blk_ff);
      sum_wdata = sum_rdata + mid_prod_ff;
      if (cmd.clear) begin
         sum_waddr = BLK_AW'(clr_ff);
         sum_wdata = '0;
      end else if (cmd.wr_write) begin
         sum_waddr = BLK_AW'(sb_ff);
         sum_wdata = sum_rdata + wr_diff64;
      end else if (cmd.close) begin
         sum_waddr = BLK_AW'(blk_ff);
         sum_wdata = sum_rdata + part_prod_ff;
      end
   end

   brs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_en   (elem_re),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   brs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BLOCK_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_en   (tag_re),
      .rd_addr (blk_raddr),
      .rd_data (tag_rdata)
   );

   brs_ram #(
      .WIDTH (SUM_W),
      .DEPTH (BLOCK_COUNT)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_en   (sum_re),
      .rd_addr (blk_raddr),
      .rd_data (sum_rdata)
   );

   // Status to the controller.
   always_comb begin
      status.clear_last = clr_ff == ELEM_AW'(MAX_ELEMENTS - 1);
      status.func       = item_ff.func;
      status.range_bad  = range_bad;
      status.at_last    = at_last;
      status.next_last  = ({1'b0, blk_ff} + (IDX_W+1)'(1)) == {1'b0, tb_ff};
      status.pos_at_end = pos_ff == end_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Element write-back and whole-block write-back never overlap.
   assert property (@(posedge clock) disable iff (reset) !(walk_vld_ff && mid_vld_ff))
      else $error("element and block write-back in the same cycle");

   // The element walk never runs past the end of its segment.
   assert property (@(posedge clock) disable iff (reset) cmd.walk |-> pos_ff <= end_ff)
      else $error("element walk beyond segment end");

   // A new result is loaded only when the previous one has been taken or leaves now.
   assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

endmodule

>>> design/block_range_add_range_sum_unit.sv
// Top level of the block range add / range sum unit: controller plus datapath.
// Depends on brs_pkg, brs_ctrl and brs_dpath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    brs_req_type (func, indices, value)
//   rsp      out        rsp_valid/rsp_ready    brs_rsp_type (range_sum, range_error)
//   csr      in         csr_valid/csr_ready    elements_in_use, 11 bits
//
// One item at a time. A write reads the element, tag and block-sum RAMs, then writes the element
// and the block sum; a range add or query walks the two end blocks at one element per cycle
// and passes over the blocks between at one block per cycle.
// After reset a clearing sweep over every element address zeroes all RAMs before req_ready rises.
// A finished result waits in an output register; the next item is accepted meanwhile, and
// a stalled rsp channel holds the unit only when a second result is ready.

module block_range_add_range_sum_unit #(
   parameter int unsigned MAX_ELEMENTS = brs_pkg::MAX_ELEMENTS_DEF,
   parameter int unsigned BLOCK_LEN    = brs_pkg::BLOCK_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  brs_pkg::brs_req_type      req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output brs_pkg::brs_rsp_type      rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [brs_pkg::CFG_W-1:0] csr_data
);

   brs_pkg::brs_cmd_type    cmd;
   brs_pkg::brs_status_type status;

   // The register is always free to take a transfer.
   assign csr_ready = 1'b1;

   brs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brs_dpath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .BLOCK_LEN    (BLOCK_LEN)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
